// ===== src/mcaa_pkg.sv =====
// Shared types, constants and register codes of the multichannel converter averager.
`default_nettype none
package mcaa_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int SLOT_W   = 3;
    localparam int MUX_W    = 5;
    localparam int RATE_W   = 8;
    localparam int Q_W      = 32;
    localparam int ACC_W    = 52;
    localparam int CNT_W    = 8;
    localparam int IDX_W    = 4;

    // Stream data widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 40;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_GAIN   = 4'd1;

    // Reset values
    localparam logic [3:0]     CHANNEL_COUNT_RST = 4'd1;
    localparam logic [Q_W-1:0] UNITY_Q16         = 32'h0001_0000;

    // Saturation limit for the scaled magnitude
    localparam logic [48:0] MAG_CAP = 49'h100_0000_0000;

    // Classified input item
    typedef struct packed {
        logic                    is_load;
        logic [SAMPLE_W-1:0]     sample;
        logic [SLOT_W-1:0]       slot;
        logic [MUX_W-1:0]        mux_input;
        logic [RATE_W-1:0]       avg_len;
        logic [Q_W-1:0]          scale;
        logic [Q_W-1:0]          offset;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULG,
        ST_ACC,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MAG,
        ST_SAT,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== src/multichannel_adc_averager_core.sv =====
// Top level: configuration registers, front end queue and back end sequencer.
// A load item passes through the load and emit states, a sample item that does
// not publish through the gain multiply, accumulate and emit states. A sample
// that publishes passes through a restoring divider for the mean, retiring one
// quotient bit per cycle over the 52-bit accumulator, then two partial products
// of the quotient and the 32-bit scale magnitude, a magnitude merge and a
// saturation step. One item is worked on at a time: the back end takes no new
// item until the last result is in the result register, and a two-entry input
// queue and a result register let input and output sides stall independently.
// Output tdata holds next_mux_input, publish_slot and value; tuser is publish.
`default_nettype none
module multichannel_adc_averager_core #(
    parameter int SLOTS       = mcaa_pkg::SLOTS_DEF,
    parameter int SAMPLE_BITS = mcaa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // sample[11:0], slot[14:12], mux_input[19:15], avg_len[27:20],
    // scale[59:28], offset[91:60], zero fill above
    input  wire logic [mcaa_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode[0]
    input  wire logic                           s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // next_mux_input[4:0], publish_slot[7:5], value[39:8]
    output logic [mcaa_pkg::M_DATA_W-1:0]       m_tdata,
    // publish[0]
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mcaa_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [mcaa_pkg::Q_W-1:0]       cfg_data
);

    logic [3:0]                channel_count_reg;
    logic [mcaa_pkg::Q_W-1:0]  sample_gain_reg;
    mcaa_pkg::queue_head_t     head;
    logic                      pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= mcaa_pkg::CHANNEL_COUNT_RST;
            sample_gain_reg   <= mcaa_pkg::UNITY_Q16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mcaa_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                mcaa_pkg::REG_SAMPLE_GAIN:   sample_gain_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    mcaa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    mcaa_back #(
        .SLOTS       (SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .channel_count (channel_count_reg),
        .sample_gain   (sample_gain_reg),
        .head          (head),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/mcaa_front.sv =====
// Front end: unpacks and classifies input items into a two-entry queue.
`default_nettype none
module mcaa_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mcaa_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    output mcaa_pkg::queue_head_t                head,
    input  wire logic                            pop
);

    mcaa_pkg::item_t  q_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    mcaa_pkg::item_t  in_item;
    logic             push;

    // Unpack fields, opcode decides the kind
    always_comb begin
        in_item.is_load   = s_tuser;
        in_item.sample    = s_tdata[11:0];
        in_item.slot      = s_tdata[14:12];
        in_item.mux_input = s_tdata[19:15];
        in_item.avg_len   = s_tdata[27:20];
        in_item.scale     = s_tdata[59:28];
        in_item.offset    = s_tdata[91:60];
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue fill out of range");

    a_head_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (head.valid && !pop) |=> (head.valid && $stable(head.item)))
        else $error("queue head changed while waiting");

endmodule
`default_nettype wire

// ===== src/mcaa_back.sv =====
// Back end: slot state, accumulate, divide, scale and the result register.
`default_nettype none
module mcaa_back #(
    parameter int SLOTS       = mcaa_pkg::SLOTS_DEF,
    parameter int SAMPLE_BITS = mcaa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [3:0]                    channel_count,
    input  wire logic [mcaa_pkg::Q_W-1:0]      sample_gain,
    input  wire mcaa_pkg::queue_head_t         head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mcaa_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [11:0] SMP_MASK = 12'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [5:0]  DIV_LAST = 6'(mcaa_pkg::ACC_W - 1);

    mcaa_pkg::state_t state_reg, state_next;
    mcaa_pkg::item_t  item_reg;

    // Slot state
    logic [SW-1:0]               cur_reg;
    logic [mcaa_pkg::ACC_W-1:0]  acc_reg    [SLOTS];
    logic [mcaa_pkg::CNT_W-1:0]  cnt_reg    [SLOTS];
    logic [mcaa_pkg::MUX_W-1:0]  mux_reg    [SLOTS];
    logic [mcaa_pkg::RATE_W-1:0] rate_reg   [SLOTS];
    logic [mcaa_pkg::Q_W-1:0]    scale_reg  [SLOTS];
    logic [mcaa_pkg::Q_W-1:0]    offset_reg [SLOTS];

    // Datapath
    logic [43:0]                 prod_reg;
    logic [mcaa_pkg::ACC_W-1:0]  div_q_reg;
    logic [7:0]                  div_rem_reg;
    logic [7:0]                  div_den_reg;
    logic [5:0]                  div_cnt_reg;
    logic                        neg_reg;
    logic [31:0]                 smag_reg;
    logic [31:0]                 offs_reg;
    logic [63:0]                 p_lo_reg;
    logic [51:0]                 p_hi_reg;
    logic [48:0]                 mag_reg;
    logic [2:0]                  pslot_reg;

    // Result register
    logic                        m_valid_reg;
    logic [4:0]                  m_mux_reg;
    logic                        m_pub_reg;
    logic [2:0]                  m_pslot_reg;
    logic [31:0]                 m_value_reg;

    logic                        out_free;
    logic                        ld_ok;
    logic [SW-1:0]               ld_idx;
    logic [mcaa_pkg::ACC_W-1:0]  acc_sum;
    logic [7:0]                  cnt_inc;
    logic [7:0]                  rate_eff;
    logic                        do_pub;
    logic [5:0]                  limit;
    logic [SW-1:0]               cur_adv;
    logic [8:0]                  rem_shift;
    logic                        rem_ge;
    logic [48:0]                 mag_sum;
    logic signed [42:0]          v_sum;
    logic [31:0]                 v_sat;

    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (state_reg == mcaa_pkg::ST_IDLE) && head.valid;
    assign ld_ok    = (6'(item_reg.slot) < 6'(SLOTS));
    assign ld_idx   = SW'(item_reg.slot);

    // Accumulate and publish decision
    assign acc_sum  = acc_reg[cur_reg] + mcaa_pkg::ACC_W'(prod_reg);
    assign cnt_inc  = cnt_reg[cur_reg] + 8'd1;
    assign rate_eff = (rate_reg[cur_reg] == 8'd0) ? 8'd1 : rate_reg[cur_reg];
    assign do_pub   = (cnt_inc >= rate_eff);

    // Round-robin advance
    assign limit   = (6'(channel_count) > 6'(SLOTS)) ? 6'(SLOTS) : 6'(channel_count);
    assign cur_adv = ((6'(cur_reg) + 6'd1) >= limit) ? '0 : SW'(6'(cur_reg) + 6'd1);

    // Restoring divide step
    assign rem_shift = {div_rem_reg, div_q_reg[mcaa_pkg::ACC_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_den_reg});

    // Magnitude merge and signed saturate
    assign mag_sum = {1'b0, p_hi_reg[31:0], 16'd0} + {1'b0, p_lo_reg[63:16]};
    assign v_sum   = (neg_reg ? -$signed({2'b00, mag_reg[40:0]})
                              : $signed({2'b00, mag_reg[40:0]}))
                   + 43'($signed(offs_reg));
    always_comb begin
        if (v_sum > 43'sd2147483647) begin
            v_sat = 32'h7FFF_FFFF;
        end else if (v_sum < -43'sd2147483648) begin
            v_sat = 32'h8000_0000;
        end else begin
            v_sat = v_sum[31:0];
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcaa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mcaa_pkg::ST_IDLE: begin
                if (head.valid) begin
                    state_next = head.item.is_load ? mcaa_pkg::ST_LOAD : mcaa_pkg::ST_MULG;
                end
            end
            mcaa_pkg::ST_LOAD:   state_next = mcaa_pkg::ST_EMIT;
            mcaa_pkg::ST_MULG:   state_next = mcaa_pkg::ST_ACC;
            mcaa_pkg::ST_ACC:    state_next = do_pub ? mcaa_pkg::ST_DIV : mcaa_pkg::ST_EMIT;
            mcaa_pkg::ST_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = mcaa_pkg::ST_MUL_LO;
                end
            end
            mcaa_pkg::ST_MUL_LO: state_next = mcaa_pkg::ST_MUL_HI;
            mcaa_pkg::ST_MUL_HI: state_next = mcaa_pkg::ST_MAG;
            mcaa_pkg::ST_MAG:    state_next = mcaa_pkg::ST_SAT;
            mcaa_pkg::ST_SAT: begin
                if (out_free) begin
                    state_next = mcaa_pkg::ST_IDLE;
                end
            end
            mcaa_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = mcaa_pkg::ST_IDLE;
                end
            end
            default: state_next = mcaa_pkg::ST_IDLE;
        endcase
    end

    // Slot table and current slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                acc_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
                mux_reg[i]    <= '0;
                rate_reg[i]   <= '0;
                scale_reg[i]  <= mcaa_pkg::UNITY_Q16;
                offset_reg[i] <= '0;
            end
        end else begin
            if (state_reg == mcaa_pkg::ST_LOAD && ld_ok) begin
                mux_reg[ld_idx]    <= item_reg.mux_input;
                rate_reg[ld_idx]   <= item_reg.avg_len;
                scale_reg[ld_idx]  <= item_reg.scale;
                offset_reg[ld_idx] <= item_reg.offset;
            end
            if (state_reg == mcaa_pkg::ST_ACC) begin
                acc_reg[cur_reg] <= do_pub ? '0 : acc_sum;
                cnt_reg[cur_reg] <= do_pub ? '0 : cnt_inc;
                cur_reg          <= cur_adv;
            end
        end
    end

    // Arithmetic datapath
    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head.item;
        end
        if (state_reg == mcaa_pkg::ST_MULG) begin
            prod_reg <= 44'(item_reg.sample & SMP_MASK) * 44'(sample_gain);
        end
        if (state_reg == mcaa_pkg::ST_ACC) begin
            div_q_reg   <= acc_sum;
            div_rem_reg <= '0;
            div_den_reg <= cnt_inc;
            div_cnt_reg <= '0;
            neg_reg     <= scale_reg[cur_reg][31];
            smag_reg    <= scale_reg[cur_reg][31] ? -scale_reg[cur_reg] : scale_reg[cur_reg];
            offs_reg    <= offset_reg[cur_reg];
            pslot_reg   <= 3'(cur_reg);
        end
        if (state_reg == mcaa_pkg::ST_DIV) begin
            div_rem_reg <= rem_ge ? 8'(rem_shift - {1'b0, div_den_reg}) : rem_shift[7:0];
            div_q_reg   <= {div_q_reg[mcaa_pkg::ACC_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        if (state_reg == mcaa_pkg::ST_MUL_LO) begin
            p_lo_reg <= 64'(div_q_reg[31:0]) * 64'(smag_reg);
        end
        if (state_reg == mcaa_pkg::ST_MUL_HI) begin
            p_hi_reg <= 52'(div_q_reg[51:32]) * 52'(smag_reg);
        end
        if (state_reg == mcaa_pkg::ST_MAG) begin
            if (p_hi_reg[51:32] != 20'd0 || mag_sum > mcaa_pkg::MAG_CAP) begin
                mag_reg <= mcaa_pkg::MAG_CAP;
            end else begin
                mag_reg <= mag_sum;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free && (state_reg == mcaa_pkg::ST_EMIT
                                  || state_reg == mcaa_pkg::ST_SAT)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && state_reg == mcaa_pkg::ST_EMIT) begin
            m_mux_reg   <= mux_reg[cur_reg];
            m_pub_reg   <= 1'b0;
            m_pslot_reg <= '0;
            m_value_reg <= '0;
        end else if (out_free && state_reg == mcaa_pkg::ST_SAT) begin
            m_mux_reg   <= mux_reg[cur_reg];
            m_pub_reg   <= 1'b1;
            m_pslot_reg <= pslot_reg;
            m_value_reg <= v_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pub_reg;
    assign m_tdata  = {m_value_reg, m_pslot_reg, m_mux_reg};

    a_cur_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        6'(cur_reg) < 6'(SLOTS))
        else $error("current slot out of range");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mcaa_pkg::ST_DIV |-> div_cnt_reg <= DIV_LAST)
        else $error("divider ran past its last step");

    a_quiet_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pub_reg) |-> (m_value_reg == 32'd0 && m_pslot_reg == 3'd0))
        else $error("non-publishing result carries a value");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == mcaa_pkg::ST_IDLE)
        else $error("item taken while back end busy");

endmodule
`default_nettype wire
